@@ hw/rtl/lob_pkg.sv @@
// ----------------------------------------------------------------------------
// lob_pkg
// Shared types, codes and sizes for the limit order book.
// ----------------------------------------------------------------------------
package lob_pkg;

  // Book dimensions.
  localparam int ORDER_SLOTS  = 1024;
  localparam int PRICE_LEVELS = 256;
  localparam int ID_W         = $clog2(ORDER_SLOTS);
  localparam int PRICE_W      = $clog2(PRICE_LEVELS);
  localparam int LVL_AW       = PRICE_W + 1;
  localparam int LVL_DEPTH    = 2 * PRICE_LEVELS;
  localparam int QTY_W        = 32;
  localparam int TOTAL_W      = 42;

  // Occupancy search geometry: words of 64 price levels.
  localparam int OCC_BITS  = 64;
  localparam int OCC_BIT_W = 6;
  localparam int OCC_WORDS = (PRICE_LEVELS + OCC_BITS - 1) / OCC_BITS;

  // Action codes.
  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_CANCEL = 3'd1;
  localparam logic [2:0] ACT_QUERY  = 3'd2;
  localparam logic [2:0] ACT_LOOKUP = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;
  // Unassigned action codes: they have no effect.
  localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
  localparam logic [2:0] ACT_RSVD_LAST  = 3'd7;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUP_ID    = 2'd2;
  localparam logic [1:0] ST_ZERO_QTY  = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic [ID_W-1:0]    slot_id;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [PRICE_W-1:0] bid_price;
    logic               has_bid;
    logic [PRICE_W-1:0] ask_price;
    logic               has_ask;
    logic [TOTAL_W-1:0] level_quantity;
    logic [ID_W-1:0]    first_order;
    logic               has_first;
    logic               found_side;
    logic [PRICE_W-1:0] found_price;
    logic [QTY_W-1:0]   found_quantity;
  } rsp_t;

  // One order slot: quantity, price, side and list links.
  typedef struct packed {
    logic [QTY_W-1:0]   quantity;
    logic [PRICE_W-1:0] price;
    logic               side;
    logic [ID_W-1:0]    prev;
    logic [ID_W-1:0]    next;
  } rec_t;

  // One price level: total quantity, oldest and newest order.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [ID_W-1:0]    head;
    logic [ID_W-1:0]    tail;
  } lvl_t;

  localparam int REC_W = $bits(rec_t);
  localparam int LVL_W = $bits(lvl_t);

  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] waddr;
    rec_t            wdata;
    logic [ID_W-1:0] raddr;
  } rec_port_t;

  typedef struct packed {
    logic              we;
    logic [LVL_AW-1:0] waddr;
    lvl_t              wdata;
    logic [LVL_AW-1:0] raddr;
  } lvl_port_t;

  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] waddr;
    logic            wdata;
    logic [ID_W-1:0] raddr;
  } live_port_t;

  // Occupancy update command from the sequencer.
  typedef struct packed {
    logic               set;
    logic               clr;
    logic               clr_all;
    logic               side;
    logic [PRICE_W-1:0] price;
  } occ_cmd_t;

  typedef struct packed {
    logic [PRICE_W-1:0] bid_price;
    logic               has_bid;
    logic [PRICE_W-1:0] ask_price;
    logic               has_ask;
  } best_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_ADD_LINK,
    S_CAN_EXEC,
    S_CAN_P,
    S_CAN_N,
    S_W1,
    S_W2,
    S_DONE
  } lob_state_t;

endpackage

@@ hw/rtl/lob_ram.sv @@
// ----------------------------------------------------------------------------
// lob_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/lob_best.sv @@
// ----------------------------------------------------------------------------
// lob_best
// Per-side occupancy bits and a two-stage registered best price search.
// ----------------------------------------------------------------------------
module lob_best (
  input  logic                     clk,
  input  logic                     rst,
  input  lob_pkg::occ_cmd_t        cmd,
  input  logic                     q_side,
  input  logic [lob_pkg::PRICE_W-1:0] q_price,
  output logic                     q_occ,
  output lob_pkg::best_t           best
);
  import lob_pkg::*;

  logic [PRICE_LEVELS-1:0] occ_bid;
  logic [PRICE_LEVELS-1:0] occ_ask;

  logic [OCC_WORDS-1:0]     bid_any, bid_any_next;
  logic [OCC_WORDS-1:0]     ask_any, ask_any_next;
  logic [OCC_BIT_W-1:0]     bid_idx [OCC_WORDS];
  logic [OCC_BIT_W-1:0]     ask_idx [OCC_WORDS];
  logic [OCC_BIT_W-1:0]     bid_idx_next [OCC_WORDS];
  logic [OCC_BIT_W-1:0]     ask_idx_next [OCC_WORDS];
  best_t                    best_next;

  // Occupancy bits.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_all) begin
      occ_bid <= '0;
      occ_ask <= '0;
    end else if (cmd.set || cmd.clr) begin
      if (cmd.side) begin
        occ_ask[cmd.price] <= cmd.set;
      end else begin
        occ_bid[cmd.price] <= cmd.set;
      end
    end
  end

  assign q_occ = q_side ? occ_ask[q_price] : occ_bid[q_price];

  // Stage one: highest bid bit and lowest ask bit within each word.
  always_comb begin
    for (int w = 0; w < OCC_WORDS; w++) begin
      bid_any_next[w] = 1'b0;
      ask_any_next[w] = 1'b0;
      bid_idx_next[w] = '0;
      ask_idx_next[w] = '0;
      for (int b = 0; b < OCC_BITS; b++) begin
        if ((w * OCC_BITS + b) < PRICE_LEVELS) begin
          if (occ_bid[w * OCC_BITS + b]) begin
            bid_any_next[w] = 1'b1;
            bid_idx_next[w] = OCC_BIT_W'(b);
          end
        end
      end
      for (int b = OCC_BITS - 1; b >= 0; b--) begin
        if ((w * OCC_BITS + b) < PRICE_LEVELS) begin
          if (occ_ask[w * OCC_BITS + b]) begin
            ask_any_next[w] = 1'b1;
            ask_idx_next[w] = OCC_BIT_W'(b);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    bid_any <= bid_any_next;
    ask_any <= ask_any_next;
    for (int w = 0; w < OCC_WORDS; w++) begin
      bid_idx[w] <= bid_idx_next[w];
      ask_idx[w] <= ask_idx_next[w];
    end
  end

  // Stage two: pick the winning word on each side.
  always_comb begin
    best_next = '0;
    for (int w = 0; w < OCC_WORDS; w++) begin
      if (bid_any[w]) begin
        best_next.has_bid   = 1'b1;
        best_next.bid_price = PRICE_W'(w * OCC_BITS + int'(bid_idx[w]));
      end
    end
    for (int w = OCC_WORDS - 1; w >= 0; w--) begin
      if (ask_any[w]) begin
        best_next.has_ask   = 1'b1;
        best_next.ask_price = PRICE_W'(w * OCC_BITS + int'(ask_idx[w]));
      end
    end
  end

  always_ff @(posedge clk) begin
    best <= best_next;
  end

endmodule

@@ hw/rtl/lob_ctrl.sv @@
// ----------------------------------------------------------------------------
// lob_ctrl
// Sequencer: reads the order, level and live memories, relinks lists and
// builds the response word.
// ----------------------------------------------------------------------------
module lob_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  lob_pkg::req_t         req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output lob_pkg::rsp_t         rsp,
  output lob_pkg::rec_port_t    rec_port,
  input  lob_pkg::rec_t         rec_q,
  output lob_pkg::lvl_port_t    lvl_port,
  input  lob_pkg::lvl_t         lvl_q,
  output lob_pkg::live_port_t   live_port,
  input  logic                  live_q,
  output lob_pkg::occ_cmd_t     occ_cmd,
  input  logic                  q_occ,
  input  lob_pkg::best_t        best
);
  import lob_pkg::*;

  lob_state_t      state, state_next;
  logic [ID_W-1:0] cnt;
  logic            clr_item;
  req_t            cur;
  rec_t            crec;
  logic [ID_W-1:0] link_id;
  logic            is_head, is_tail;
  rsp_t            res;
  rsp_t            rsp_next;
  logic            hit_head, hit_tail;
  logic            rsp_load;

  assign hit_head = (lvl_q.head == cur.slot_id);
  assign hit_tail = (lvl_q.tail == cur.slot_id);
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp_ready);

  // Next state and memory port control.
  always_comb begin
    state_next     = state;
    req_ready      = 1'b0;
    rec_port       = '0;
    rec_port.raddr = cur.slot_id;
    lvl_port       = '0;
    lvl_port.raddr = {cur.side, cur.price};
    live_port      = '0;
    live_port.raddr = cur.slot_id;
    occ_cmd        = '0;
    occ_cmd.side   = cur.side;
    occ_cmd.price  = cur.price;

    unique case (state)
      S_CLR: begin
        live_port.we    = 1'b1;
        live_port.waddr = cnt;
        live_port.wdata = 1'b0;
        if (cnt == ID_W'(ORDER_SLOTS - 1)) begin
          state_next = clr_item ? S_W1 : S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_W1;
        unique case (cur.action)
          ACT_ADD: begin
            if (!live_q && cur.quantity != '0) begin
              rec_port.we             = 1'b1;
              rec_port.waddr          = cur.slot_id;
              rec_port.wdata.quantity = cur.quantity;
              rec_port.wdata.price    = cur.price;
              rec_port.wdata.side     = cur.side;
              rec_port.wdata.next     = '0;
              rec_port.wdata.prev     = q_occ ? lvl_q.tail : '0;
              lvl_port.we             = 1'b1;
              lvl_port.waddr          = {cur.side, cur.price};
              lvl_port.wdata.tail     = cur.slot_id;
              live_port.we            = 1'b1;
              live_port.waddr         = cur.slot_id;
              live_port.wdata         = 1'b1;
              if (q_occ) begin
                // Append behind the current tail, which must be relinked.
                lvl_port.wdata.total = lvl_q.total + TOTAL_W'(cur.quantity);
                lvl_port.wdata.head  = lvl_q.head;
                rec_port.raddr       = lvl_q.tail;
                state_next           = S_ADD_LINK;
              end else begin
                lvl_port.wdata.total = TOTAL_W'(cur.quantity);
                lvl_port.wdata.head  = cur.slot_id;
                occ_cmd.set          = 1'b1;
              end
            end
          end
          ACT_CANCEL: begin
            if (live_q) begin
              lvl_port.raddr = {rec_q.side, rec_q.price};
              state_next     = S_CAN_EXEC;
            end
          end
          ACT_CLEAR: begin
            occ_cmd.clr_all = 1'b1;
            state_next      = S_CLR;
          end
          default: begin
            state_next = S_W1;
          end
        endcase
      end
      S_ADD_LINK: begin
        rec_port.we         = 1'b1;
        rec_port.waddr      = link_id;
        rec_port.wdata      = rec_q;
        rec_port.wdata.next = cur.slot_id;
        state_next          = S_W1;
      end
      S_CAN_EXEC: begin
        live_port.we    = 1'b1;
        live_port.waddr = cur.slot_id;
        live_port.wdata = 1'b0;
        lvl_port.we     = 1'b1;
        lvl_port.waddr  = {crec.side, crec.price};
        occ_cmd.side    = crec.side;
        occ_cmd.price   = crec.price;
        if (hit_head && hit_tail) begin
          // Last order at the level: the level empties.
          occ_cmd.clr          = 1'b1;
          lvl_port.wdata.total = '0;
          lvl_port.wdata.head  = lvl_q.head;
          lvl_port.wdata.tail  = lvl_q.tail;
        end else begin
          lvl_port.wdata.total = lvl_q.total - TOTAL_W'(crec.quantity);
          lvl_port.wdata.head  = hit_head ? crec.next : lvl_q.head;
          lvl_port.wdata.tail  = hit_tail ? crec.prev : lvl_q.tail;
        end
        rec_port.raddr = crec.prev;
        state_next     = S_CAN_P;
      end
      S_CAN_P: begin
        // Older neighbor now points past the cancelled order.
        if (!is_head) begin
          rec_port.we         = 1'b1;
          rec_port.waddr      = crec.prev;
          rec_port.wdata      = rec_q;
          rec_port.wdata.next = crec.next;
        end
        rec_port.raddr = crec.next;
        state_next     = S_CAN_N;
      end
      S_CAN_N: begin
        // Newer neighbor now points back past the cancelled order.
        if (!is_tail) begin
          rec_port.we         = 1'b1;
          rec_port.waddr      = crec.next;
          rec_port.wdata      = rec_q;
          rec_port.wdata.prev = crec.prev;
        end
        state_next = S_W1;
      end
      S_W1: begin
        state_next = S_W2;
      end
      S_W2: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Response word with the best prices after the change.
  always_comb begin
    rsp_next           = res;
    rsp_next.bid_price = best.bid_price;
    rsp_next.has_bid   = best.has_bid;
    rsp_next.ask_price = best.ask_price;
    rsp_next.has_ask   = best.has_ask;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      clr_item  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) begin
        cnt <= (cnt == ID_W'(ORDER_SLOTS - 1)) ? '0 : cnt + 1'b1;
        if (cnt == ID_W'(ORDER_SLOTS - 1)) begin
          clr_item <= 1'b0;
        end
      end else if (state == S_EXEC && cur.action == ACT_CLEAR) begin
        clr_item <= 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Item, record copy and response fields.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      cur <= req;
      res <= '0;
    end
    if (state == S_EXEC) begin
      crec    <= rec_q;
      link_id <= lvl_q.tail;
      unique case (cur.action)
        ACT_ADD: begin
          if (live_q) begin
            res.status <= ST_DUP_ID;
          end else if (cur.quantity == '0) begin
            res.status <= ST_ZERO_QTY;
          end
        end
        ACT_CANCEL: begin
          if (!live_q) begin
            res.status <= ST_NOT_FOUND;
          end
        end
        ACT_QUERY: begin
          if (q_occ) begin
            res.level_quantity <= lvl_q.total;
            res.first_order    <= lvl_q.head;
            res.has_first      <= 1'b1;
          end
        end
        ACT_LOOKUP: begin
          if (live_q) begin
            res.found_side     <= rec_q.side;
            res.found_price    <= rec_q.price;
            res.found_quantity <= rec_q.quantity;
          end else begin
            res.status <= ST_NOT_FOUND;
          end
        end
        default: begin
        end
      endcase
    end
    if (state == S_CAN_EXEC) begin
      is_head <= hit_head;
      is_tail <= hit_tail;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ hw/rtl/limit_order_book.sv @@
// ----------------------------------------------------------------------------
// limit_order_book
// Resting limit order book with price-time priority per level.
//
//   channel | direction | handshake             | word
//   req     | in        | req_valid / req_ready | lob_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_ready | lob_pkg::rsp_t
//
// Each accepted word passes through the read, execute, wait (S_W1, S_W2) and
// done states. An add behind a resting order inserts a link state; a cancel of
// a live order inserts states that rewrite its level and relink its neighbors.
// Registered reads of the order and level memories and the two-stage best
// price search after every change set this sequence. Clear sweeps the live
// memory, one slot a cycle. After reset the same sweep runs with req_ready low.
// A new word is taken while the previous response still waits on rsp_ready.
// ----------------------------------------------------------------------------
module limit_order_book (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  lob_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output lob_pkg::rsp_t  rsp
);
  import lob_pkg::*;

  rec_port_t            rec_port;
  lvl_port_t            lvl_port;
  live_port_t           live_port;
  logic [REC_W-1:0]     rec_rdata;
  logic [LVL_W-1:0]     lvl_rdata;
  logic [0:0]           live_rdata;
  occ_cmd_t             occ_cmd;
  logic                 q_occ;
  best_t                best;

  // Order records.
  lob_ram #(.WIDTH(REC_W), .DEPTH(ORDER_SLOTS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_port.we),
    .waddr (rec_port.waddr),
    .wdata (rec_port.wdata),
    .raddr (rec_port.raddr),
    .rdata (rec_rdata)
  );

  // Level totals and list ends.
  lob_ram #(.WIDTH(LVL_W), .DEPTH(LVL_DEPTH)) u_lvl_ram (
    .clk   (clk),
    .we    (lvl_port.we),
    .waddr (lvl_port.waddr),
    .wdata (lvl_port.wdata),
    .raddr (lvl_port.raddr),
    .rdata (lvl_rdata)
  );

  // Live flag per order slot.
  lob_ram #(.WIDTH(1), .DEPTH(ORDER_SLOTS)) u_live_ram (
    .clk   (clk),
    .we    (live_port.we),
    .waddr (live_port.waddr),
    .wdata (live_port.wdata),
    .raddr (live_port.raddr),
    .rdata (live_rdata)
  );

  // Occupancy probe for the level of the item in hand.
  lob_best u_best (
    .clk     (clk),
    .rst     (rst),
    .cmd     (occ_cmd),
    .q_side  (occ_cmd.side),
    .q_price (occ_cmd.price),
    .q_occ   (q_occ),
    .best    (best)
  );

  lob_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .rec_port  (rec_port),
    .rec_q     (rec_rdata),
    .lvl_port  (lvl_port),
    .lvl_q     (lvl_rdata),
    .live_port (live_port),
    .live_q    (live_rdata[0]),
    .occ_cmd   (occ_cmd),
    .q_occ     (q_occ),
    .best      (best)
  );

`ifndef SYNTH
  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("item accepted while another is in work");

  // The clearing sweep holds off input right after reset.
  a_reset_sweep: assert property (@(posedge clk)
    $past(rst) |-> !req_ready)
    else $error("input accepted during the reset sweep");

  // A level cannot be both set and cleared in one cycle.
  a_occ_cmd: assert property (@(posedge clk) disable iff (rst)
    !(occ_cmd.set && occ_cmd.clr))
    else $error("conflicting occupancy update");

  // A failed action carries no query or lookup answer.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |->
      (rsp.found_quantity == '0 && rsp.level_quantity == '0 && !rsp.has_first))
    else $error("answer fields set on a failed action");
`endif

endmodule

@@ tb/limit_order_book_test.sv @@
// ----------------------------------------------------------------------------
// limit_order_book_test
// Drives add, cancel, level query, lookup, clear and unassigned words into the
// order book and checks every response against a behavioral book in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module limit_order_book_test;
  import lob_pkg::*;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_ready = 1'b0;
  rsp_t  rsp;

  // Idle percentages for each side; zero disables gaps.
  int    send_gap_pct = 0;
  int    recv_stall_pct = 0;
  int    mismatches = 0;
  rsp_t  pending_rsp[$];

  // Behavioral book state.
  bit                 slot_live [ORDER_SLOTS];
  logic [QTY_W-1:0]   slot_qty  [ORDER_SLOTS];
  logic [PRICE_W-1:0] slot_price[ORDER_SLOTS];
  logic               slot_side [ORDER_SLOTS];
  // Per level, the time-ordered list of resting slots (oldest first).
  int                 level_fifo[2*PRICE_LEVELS][$];

  limit_order_book i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Apply one word to the book and return the expected response.
  function automatic rsp_t book_apply(req_t w);
    rsp_t r;
    int   lv;
    r = '0;
    lv = int'(w.side) * PRICE_LEVELS + int'(w.price);
    case (w.action)
      ACT_ADD: begin
        if (slot_live[w.slot_id]) r.status = ST_DUP_ID;
        else if (w.quantity == 0) r.status = ST_ZERO_QTY;
        else begin
          slot_live[w.slot_id] = 1'b1;
          slot_qty[w.slot_id] = w.quantity;
          slot_price[w.slot_id] = w.price;
          slot_side[w.slot_id] = w.side;
          level_fifo[lv].insert(level_fifo[lv].size(), int'(w.slot_id));
        end
      end
      ACT_CANCEL: begin
        if (!slot_live[w.slot_id]) r.status = ST_NOT_FOUND;
        else begin
          lv = int'(slot_side[w.slot_id]) * PRICE_LEVELS + int'(slot_price[w.slot_id]);
          foreach (level_fifo[lv][k])
            if (level_fifo[lv][k] == w.slot_id) begin
              level_fifo[lv].delete(k);
              break;
            end
          slot_live[w.slot_id] = 1'b0;
        end
      end
      ACT_QUERY: begin
        if (level_fifo[lv].size() != 0) begin
          r.level_quantity = '0;
          foreach (level_fifo[lv][k])
            r.level_quantity += TOTAL_W'(slot_qty[level_fifo[lv][k]]);
          r.first_order = ID_W'(level_fifo[lv][0]);
          r.has_first = 1'b1;
        end
      end
      ACT_LOOKUP: begin
        if (slot_live[w.slot_id]) begin
          r.found_side = slot_side[w.slot_id];
          r.found_price = slot_price[w.slot_id];
          r.found_quantity = slot_qty[w.slot_id];
        end else r.status = ST_NOT_FOUND;
      end
      ACT_CLEAR: begin
        foreach (slot_live[k]) slot_live[k] = 1'b0;
        foreach (level_fifo[k]) level_fifo[k].delete();
      end
      default: ;
    endcase
    // Best prices after the change.
    for (int p = PRICE_LEVELS - 1; p >= 0; p--)
      if (level_fifo[p].size() != 0) begin
        r.bid_price = PRICE_W'(p);
        r.has_bid = 1'b1;
        break;
      end
    for (int p = 0; p < PRICE_LEVELS; p++)
      if (level_fifo[PRICE_LEVELS + p].size() != 0) begin
        r.ask_price = PRICE_W'(p);
        r.has_ask = 1'b1;
        break;
      end
    return r;
  endfunction

  // Send one word, with an optional random gap before it.
  task automatic send_word(req_t w);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_rsp.insert(pending_rsp.size(), book_apply(w));
    @(negedge clk);
  endtask

  task automatic send_fields(logic [2:0] act, int id, bit sd, int pr, logic [31:0] q);
    req_t w;
    w.action = act;
    w.slot_id = ID_W'(id);
    w.side = sd;
    w.price = PRICE_W'(pr);
    w.quantity = q;
    send_word(w);
  endtask

  // Receiver stalls are chosen at every falling edge.
  always @(negedge clk)
    rsp_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);

  // Compare each accepted response with the oldest expectation.
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected response %h", rsp);
      end else begin
        e = pending_rsp.pop_front();
        if (rsp !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: expected %h, actual %h", $realtime, e, rsp);
        end
      end
    end
  end

  // Extremes of fields, every action and each rejection path.
  task automatic test_directed();
    send_fields(ACT_LOOKUP, 0, 0, 0, 0);
    send_fields(ACT_CANCEL, 1023, 0, 0, 0);
    send_fields(ACT_QUERY, 0, 1, 255, 0);
    send_fields(ACT_ADD, 0, 0, 0, 32'hFFFF_FFFF);
    send_fields(ACT_ADD, 1023, 0, 255, 1);
    send_fields(ACT_ADD, 5, 1, 255, 7);
    send_fields(ACT_ADD, 6, 1, 0, 32'hFFFF_FFFF);
    send_fields(ACT_ADD, 7, 1, 0, 32'hFFFF_FFFF);
    send_fields(ACT_ADD, 8, 1, 0, 3);
    send_fields(ACT_ADD, 0, 1, 3, 9);
    send_fields(ACT_ADD, 9, 0, 4, 0);
    send_fields(ACT_QUERY, 0, 1, 0, 0);
    send_fields(ACT_CANCEL, 7, 0, 0, 0);
    send_fields(ACT_QUERY, 0, 1, 0, 0);
    send_fields(ACT_CANCEL, 6, 0, 0, 0);
    send_fields(ACT_QUERY, 0, 1, 0, 0);
    send_fields(ACT_LOOKUP, 1023, 0, 0, 0);
    send_fields(ACT_LOOKUP, 8, 0, 0, 0);
    send_fields(ACT_RSVD_FIRST, 1023, 1, 255, 32'hFFFF_FFFF);
    send_fields(ACT_RSVD_LAST, 0, 0, 0, 0);
    send_fields(ACT_CANCEL, 8, 0, 0, 0);
    send_fields(ACT_CLEAR, 0, 0, 0, 0);
    send_fields(ACT_QUERY, 0, 0, 255, 0);
    send_fields(ACT_ADD, 1023, 1, 128, 2);
  endtask

  // Random traffic on a small set of slots and prices so levels fill up.
  task automatic test_random(int count);
    req_t w;
    int   pick;
    repeat (count) begin
      w.slot_id = ($urandom_range(9) == 0) ? ID_W'($urandom_range(1023)) :
                                             ID_W'($urandom_range(31));
      w.side = 1'($urandom_range(1));
      w.price = ($urandom_range(9) == 0) ? PRICE_W'($urandom_range(255)) :
                                           PRICE_W'(120 + $urandom_range(15));
      w.quantity = ($urandom_range(19) == 0) ? 32'd0 :
                   ($urandom_range(4) == 0) ? $urandom : $urandom_range(1000, 1);
      pick = $urandom_range(99);
      if (pick < 40) w.action = ACT_ADD;
      else if (pick < 65) w.action = ACT_CANCEL;
      else if (pick < 80) w.action = ACT_QUERY;
      else if (pick < 95) w.action = ACT_LOOKUP;
      else if (pick < 97) w.action = ACT_CLEAR;
      else w.action = ACT_RSVD_FIRST + 3'($urandom_range(2));
      send_word(w);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(200);
    send_gap_pct = 74;
    test_random(200);
    send_gap_pct = 0;
    recv_stall_pct = 74;
    test_random(200);
    send_gap_pct = 28;
    recv_stall_pct = 28;
    test_random(200);
    drain();
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/lob_pkg.sv
hw/rtl/lob_ram.sv
hw/rtl/lob_best.sv
hw/rtl/lob_ctrl.sv
hw/rtl/limit_order_book.sv
tb/limit_order_book_test.sv
